@@ design/dstq_pkg.sv @@
// Shared types and codes for the deadline-sorted task queue.
// No dependencies; used by dstq_seq and deadline_sorted_task_queue.
`default_nettype none

package dstq_pkg;

  // Operation codes carried on the opcode field.
  localparam logic [1:0] OP_CREATE   = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_TIMEOUT  = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One queue slot as stored in the entry memory.
  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  task_id;
    logic [31:0] start_tick;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         status;
    logic               head_valid;
    logic [7:0]         head_task;
    logic signed [31:0] sleep_ticks;
    logic [7:0]         moved_task;
    logic [31:0]        moved_release;
    logic [4:0]         active_count;
    logic [15:0]        completed_count;
    logic [15:0]        overdue_count;
  } result_t;

endpackage

`default_nettype wire

@@ design/dstq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/dstq_seq.sv @@
// Sequencer for the deadline-sorted task queue: walks the entry memory to
// insert or remove a slot, then reads the head. Uses dstq_pkg and dstq_ram.
`default_nettype none

module dstq_seq #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        task_id,
  input  wire logic [31:0]       deadline,
  input  wire logic [31:0]       now_ticks,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output dstq_pkg::result_t      res
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_PUT  = 6'b000100,
    S_DEL  = 6'b001000,
    S_HEAD = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state;
  logic [1:0]         op_q;
  logic [7:0]         id_q;
  logic [31:0]        dl_q;
  logic [31:0]        now_q;
  logic [CNT_W-1:0]   len;
  logic [CNT_W-1:0]   hole;
  logic [IDX_W-1:0]   idx;
  logic               found;
  logic [7:0]         moved_task;
  logic [31:0]        moved_release;
  logic [1:0]         status_q;
  logic [15:0]        done_total;
  logic [15:0]        late_total;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  dstq_pkg::entry_t     wr_data;
  dstq_pkg::entry_t     rd_data;
  dstq_pkg::entry_t     new_entry;

  logic accept;
  logic is_full;
  logic is_empty;
  logic shift_up;
  logic last;
  logic match;

  dstq_ram #(
    .WIDTH ($bits(dstq_pkg::entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_full   = (len >= CNT_W'(MAX_TASKS));
  assign is_empty  = (len == '0);
  assign new_entry = '{deadline: dl_q, task_id: id_q, start_tick: now_q};
  // While inserting, an entry with a later deadline moves up one slot.
  assign shift_up  = (rd_data.deadline > dl_q);
  assign last      = ((CNT_W'(idx) + CNT_W'(1)) == len);
  assign match     = (op_q == dstq_pkg::OP_TIMEOUT) ? (idx == '0)
                                                    : (rd_data.task_id == id_q);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (accept && !is_empty) begin
          if (opcode == dstq_pkg::OP_CREATE && !is_full) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(len - CNT_W'(1));
          end else if (opcode == dstq_pkg::OP_COMPLETE ||
                       opcode == dstq_pkg::OP_TIMEOUT) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(hole);
        if (shift_up) begin
          wr_data = rd_data;
          if (hole >= CNT_W'(2)) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(hole - CNT_W'(2));
          end
        end else begin
          wr_data = new_entry;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_entry;
      end
      S_DEL: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = idx - IDX_W'(1);
        end
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = idx + IDX_W'(1);
        end
      end
      S_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      done_total <= '0;
      late_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q          <= opcode;
            id_q          <= task_id;
            dl_q          <= deadline;
            now_q         <= now_ticks;
            found         <= 1'b0;
            moved_task    <= '0;
            moved_release <= '0;
            status_q      <= dstq_pkg::ST_OK;
            idx           <= '0;
            hole          <= len;
            unique case (opcode)
              dstq_pkg::OP_CREATE: begin
                if (is_full) begin
                  status_q <= dstq_pkg::ST_FULL;
                  state    <= S_HEAD;
                end else if (is_empty) begin
                  state <= S_PUT;
                end else begin
                  state <= S_INS;
                end
              end
              dstq_pkg::OP_COMPLETE: begin
                if (is_empty) begin
                  status_q <= dstq_pkg::ST_NOT_FOUND;
                  state    <= S_HEAD;
                end else begin
                  state <= S_DEL;
                end
              end
              dstq_pkg::OP_TIMEOUT: begin
                if (is_empty) begin
                  status_q <= dstq_pkg::ST_EMPTY;
                  state    <= S_HEAD;
                end else begin
                  state <= S_DEL;
                end
              end
              default: begin
                state <= S_HEAD;
              end
            endcase
          end
        end
        S_INS: begin
          if (shift_up) begin
            hole <= hole - CNT_W'(1);
            if (hole == CNT_W'(1)) begin
              state <= S_PUT;
            end
          end else begin
            len   <= len + CNT_W'(1);
            state <= S_HEAD;
          end
        end
        S_PUT: begin
          len   <= len + CNT_W'(1);
          state <= S_HEAD;
        end
        S_DEL: begin
          if (!found && match) begin
            found         <= 1'b1;
            moved_task    <= rd_data.task_id;
            moved_release <= rd_data.start_tick;
          end
          if (!last) begin
            idx <= idx + IDX_W'(1);
          end else begin
            if (found || match) begin
              len <= len - CNT_W'(1);
              if (op_q == dstq_pkg::OP_TIMEOUT) begin
                if (late_total != dstq_pkg::COUNT_MAX) begin
                  late_total <= late_total + 16'd1;
                end
              end else if (done_total != dstq_pkg::COUNT_MAX) begin
                done_total <= done_total + 16'd1;
              end
            end else begin
              status_q <= dstq_pkg::ST_NOT_FOUND;
            end
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The head read lands in S_DONE and the read port stays idle there, so
  // rd_data holds slot 0 for as long as the result waits.
  assign res_valid = (state == S_DONE);

  always_comb begin
    res                 = '0;
    res.status          = status_q;
    res.moved_task      = moved_task;
    res.moved_release   = moved_release;
    res.active_count    = 5'(len);
    res.completed_count = done_total;
    res.overdue_count   = late_total;
    if (!is_empty) begin
      res.head_valid  = 1'b1;
      res.head_task   = rd_data.task_id;
      res.sleep_ticks = signed'(rd_data.deadline - now_q);
    end
  end

endmodule

`default_nettype wire

@@ design/deadline_sorted_task_queue.sv @@
// Top level of the earliest-deadline-first task queue: sequencer plus output
// register. Uses dstq_pkg and dstq_seq (which holds the dstq_ram entry memory).
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    opcode, task_id, deadline, now_ticks
//   out      out_valid / out_ready  status, head_valid, head_task, sleep_ticks,
//                                   moved_task, moved_release, active_count,
//                                   completed_count, overdue_count
//
// A create occupies the sequencer while it moves up one slot each of the S
// queued tasks with a later deadline, then writes the new task; a complete or
// a timeout walks over all L queued tasks; a status query, a create into a
// full queue or a complete or timeout on an empty queue skips the walk and
// only reads the head. The worst case is set by the walk over the entry
// memory, which reads and writes at most one slot each per cycle.
// Reset (rst, synchronous) empties the queue and clears both counters; the
// slot memory itself is not cleared. A stalled out channel holds one result
// in the output register while the next item is already taken and worked on.
`default_nettype none

module deadline_sorted_task_queue #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         opcode,
  input  wire logic [7:0]         task_id,
  input  wire logic [31:0]        deadline,
  input  wire logic [31:0]        now_ticks,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic                    head_valid,
  output logic [7:0]              head_task,
  output logic signed [31:0]      sleep_ticks,
  output logic [7:0]              moved_task,
  output logic [31:0]             moved_release,
  output logic [4:0]              active_count,
  output logic [15:0]             completed_count,
  output logic [15:0]             overdue_count
);

  logic              res_valid;
  logic              res_ready;
  dstq_pkg::result_t res;
  dstq_pkg::result_t out_q;

  // The sequencer walks the sorted slots in memory and produces one result
  // per accepted item.
  dstq_seq #(
    .MAX_TASKS (MAX_TASKS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .task_id   (task_id),
    .deadline  (deadline),
    .now_ticks (now_ticks),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register takes a new result whenever it is empty or its
  // current result is being transferred in this cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign status          = out_q.status;
  assign head_valid      = out_q.head_valid;
  assign head_task       = out_q.head_task;
  assign sleep_ticks     = out_q.sleep_ticks;
  assign moved_task      = out_q.moved_task;
  assign moved_release   = out_q.moved_release;
  assign active_count    = out_q.active_count;
  assign completed_count = out_q.completed_count;
  assign overdue_count   = out_q.overdue_count;

endmodule

`default_nettype wire
